// ===== rtl/abpm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the aged buffer pool manager.
// Holds sizes, command and register codes, controller states and the
// control and status structs shared by the controller and the datapath.
package abpm_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W    = 2;
    localparam int CNT_W     = 3;
    localparam int AGE_W     = 16;
    localparam int IDLE_W    = 11;
    localparam int TRIM_W    = 10;
    localparam int LIMIT_W   = 3;
    localparam int CMD_W     = 3;
    localparam int SIZE_W    = 16;
    localparam int CFG_W     = 10;

    localparam logic [AGE_W-1:0]   AGE_MAX     = '1;
    localparam logic [IDLE_W-1:0]  IDLE_MAX    = '1;
    localparam logic [TRIM_W-1:0]  TRIM_RESET  = 10'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ASSIGN   = 3'd0,
        CMD_POST     = 3'd1,
        CMD_RELEASE  = 3'd2,
        CMD_RECONFIG = 3'd3,
        CMD_FLUSH    = 3'd4
    } t_cmd;

    typedef enum logic {
        CFG_TRIM  = 1'b0,
        CFG_LIMIT = 1'b1
    } t_cfg_addr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ASSIGN,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic do_assign;
        logic do_exec;
    } t_dp_ctrl;

    typedef struct packed {
        logic trim_hit;
    } t_dp_status;

endpackage

// ===== rtl/abpm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the aged buffer pool manager.
// Uses abpm_pkg and drives the datapath through t_dp_ctrl.
module abpm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [abpm_pkg::CMD_W-1:0]     i_cmd,
    input  abpm_pkg::t_dp_status           i_status,
    output logic                           busy,
    output abpm_pkg::t_dp_ctrl             o_ctrl
);

    abpm_pkg::t_state r_state;
    abpm_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            abpm_pkg::ST_IDLE: begin
                if (start) begin
                    if (abpm_pkg::t_cmd'(i_cmd) == abpm_pkg::CMD_ASSIGN) begin
                        n_state = abpm_pkg::ST_SCAN;
                    end else begin
                        n_state = abpm_pkg::ST_EXEC;
                    end
                end
            end
            abpm_pkg::ST_SCAN: begin
                if (!i_status.trim_hit) begin
                    n_state = abpm_pkg::ST_ASSIGN;
                end
            end
            abpm_pkg::ST_ASSIGN: begin
                n_state = abpm_pkg::ST_IDLE;
            end
            abpm_pkg::ST_EXEC: begin
                n_state = abpm_pkg::ST_IDLE;
            end
            default: begin
                n_state = abpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        busy   = 1'b1;
        case (r_state)
            abpm_pkg::ST_IDLE: begin
                busy        = 1'b0;
                o_ctrl.load = start;
            end
            abpm_pkg::ST_SCAN: begin
                o_ctrl.scan_step = 1'b1;
            end
            abpm_pkg::ST_ASSIGN: begin
                o_ctrl.do_assign = 1'b1;
            end
            abpm_pkg::ST_EXEC: begin
                o_ctrl.do_exec = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abpm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_scan_from_assign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abpm_pkg::ST_SCAN) |->
            ($past(r_state) == abpm_pkg::ST_SCAN || $past(r_state) == abpm_pkg::ST_IDLE))
        else $error("scan entered from an unexpected state");

endmodule

// ===== rtl/abpm_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the aged buffer pool manager: slot flags, ages, insertion
// order, idle-run counter, configuration registers and result registers.
// Uses abpm_pkg and is sequenced by abpm_ctrl.
module abpm_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  abpm_pkg::t_dp_ctrl              i_ctrl,
    output abpm_pkg::t_dp_status            o_status,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_addr,
    input  logic [abpm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [abpm_pkg::CMD_W-1:0]      i_cmd,
    input  logic [abpm_pkg::SLOT_W-1:0]     i_slot,
    input  logic                            i_purge,
    input  logic [abpm_pkg::SIZE_W-1:0]     i_width,
    input  logic [abpm_pkg::SIZE_W-1:0]     i_height,
    output logic                            o_done,
    output logic [abpm_pkg::SLOT_W-1:0]     o_result_slot,
    output logic                            o_result_valid,
    output logic [abpm_pkg::AGE_W-1:0]      o_frame_age,
    output logic                            o_created,
    output logic [abpm_pkg::NUM_SLOTS-1:0]  o_destroy_mask,
    output logic [abpm_pkg::NUM_SLOTS-1:0]  o_dropped_mask
);

    localparam int N = abpm_pkg::NUM_SLOTS;

    logic [N-1:0]                          r_in_use, n_in_use;
    logic [N-1:0]                          r_busy, n_busy;
    logic [N-1:0][abpm_pkg::AGE_W-1:0]     r_age, n_age;
    logic [N-1:0][abpm_pkg::SLOT_W-1:0]    r_order, n_order;
    logic [abpm_pkg::CNT_W-1:0]            r_count, n_count;
    logic [abpm_pkg::SLOT_W-1:0]           r_cur, n_cur;
    logic                                  r_cur_v, n_cur_v;
    logic [abpm_pkg::IDLE_W-1:0]           r_idle, n_idle;
    logic [abpm_pkg::TRIM_W-1:0]           r_trim, n_trim;
    logic [abpm_pkg::LIMIT_W-1:0]          r_limit, n_limit;
    logic [N-1:0]                          r_dmask, n_dmask;
    logic [abpm_pkg::CMD_W-1:0]            r_cmd, n_cmd;
    logic [abpm_pkg::SLOT_W-1:0]           r_rel, n_rel;
    logic                                  r_purge, n_purge;
    logic                                  r_size_ok, n_size_ok;
    logic                                  r_done, n_done;
    logic [abpm_pkg::SLOT_W-1:0]           r_o_slot, n_o_slot;
    logic                                  r_o_valid, n_o_valid;
    logic [abpm_pkg::AGE_W-1:0]            r_o_age, n_o_age;
    logic                                  r_o_created, n_o_created;
    logic [N-1:0]                          r_o_dmask, n_o_dmask;
    logic [N-1:0]                          r_o_drop, n_o_drop;

    logic [N-1:0]                          free_slots;
    logic [N-1:0][abpm_pkg::SLOT_W-1:0]    slot_pos;
    logic                                  found;
    logic [abpm_pkg::SLOT_W-1:0]           best_slot;
    logic [abpm_pkg::SLOT_W-1:0]           best_pos;
    logic [abpm_pkg::AGE_W-1:0]            peak_age;
    logic [abpm_pkg::IDLE_W-1:0]           idle_inc;
    logic [abpm_pkg::IDLE_W-1:0]           new_idle;
    logic                                  trim_hit;
    logic [abpm_pkg::CNT_W-1:0]            limit_eff;
    logic                                  can_create;
    logic [abpm_pkg::SLOT_W-1:0]           new_slot;

    function automatic logic [abpm_pkg::AGE_W-1:0] age_inc(
        input logic [abpm_pkg::AGE_W-1:0] age
    );
        if (age == abpm_pkg::AGE_MAX) begin
            return age;
        end
        return age + 1'b1;
    endfunction

    always_comb begin
        for (int s = 0; s < N; s++) begin
            free_slots[s] = r_in_use[s] & ~r_busy[s];
            slot_pos[s]   = '0;
            for (int p = 0; p < N; p++) begin
                if (abpm_pkg::CNT_W'(p) < r_count &&
                    r_order[p] == abpm_pkg::SLOT_W'(s)) begin
                    slot_pos[s] = abpm_pkg::SLOT_W'(p);
                end
            end
        end
        found     = 1'b0;
        best_slot = '0;
        best_pos  = '0;
        peak_age  = '0;
        for (int s = 0; s < N; s++) begin
            if (free_slots[s] && (!found || r_age[s] > peak_age ||
                (r_age[s] == peak_age && slot_pos[s] < best_pos))) begin
                found     = 1'b1;
                best_slot = abpm_pkg::SLOT_W'(s);
                best_pos  = slot_pos[s];
                peak_age  = r_age[s];
            end
        end
        new_slot = '0;
        for (int s = N - 1; s >= 0; s--) begin
            if (!r_in_use[s]) begin
                new_slot = abpm_pkg::SLOT_W'(s);
            end
        end
    end

    assign idle_inc   = (r_idle == abpm_pkg::IDLE_MAX) ? r_idle : r_idle + 1'b1;
    assign new_idle   = ($countones(free_slots) >= 2) ? idle_inc : '0;
    assign trim_hit   = found && (new_idle > {1'b0, r_trim});
    assign limit_eff  = (r_limit > abpm_pkg::CNT_W'(N)) ? abpm_pkg::CNT_W'(N) : r_limit;
    assign can_create = !found && (r_count < limit_eff);

    assign o_status.trim_hit = trim_hit;

    always_comb begin
        n_in_use    = r_in_use;
        n_busy      = r_busy;
        n_age       = r_age;
        n_order     = r_order;
        n_count     = r_count;
        n_cur       = r_cur;
        n_cur_v     = r_cur_v;
        n_idle      = r_idle;
        n_trim      = r_trim;
        n_limit     = r_limit;
        n_dmask     = r_dmask;
        n_cmd       = r_cmd;
        n_rel       = r_rel;
        n_purge     = r_purge;
        n_size_ok   = r_size_ok;
        n_done      = 1'b0;
        n_o_slot    = r_o_slot;
        n_o_valid   = r_o_valid;
        n_o_age     = r_o_age;
        n_o_created = r_o_created;
        n_o_dmask   = r_o_dmask;
        n_o_drop    = r_o_drop;

        if (i_cfg_valid) begin
            case (abpm_pkg::t_cfg_addr'(i_cfg_addr))
                abpm_pkg::CFG_TRIM: begin
                    n_trim = i_cfg_data;
                end
                abpm_pkg::CFG_LIMIT: begin
                    n_limit = i_cfg_data[abpm_pkg::LIMIT_W-1:0];
                end
                default: begin
                    n_trim = r_trim;
                end
            endcase
        end

        if (i_ctrl.load) begin
            n_cmd     = i_cmd;
            n_rel     = i_slot;
            n_purge   = i_purge;
            n_size_ok = (i_width != '0) && (i_height != '0);
            n_dmask   = '0;
        end

        if (i_ctrl.scan_step) begin
            if (trim_hit) begin
                // Destroy the oldest free slot and close the gap in the order.
                n_idle              = '0;
                n_dmask[best_slot]  = 1'b1;
                n_in_use[best_slot] = 1'b0;
                n_busy[best_slot]   = 1'b0;
                n_age[best_slot]    = '0;
                if (r_cur_v && r_cur == best_slot) begin
                    n_cur_v = 1'b0;
                end
                for (int p = 0; p < N - 1; p++) begin
                    if (abpm_pkg::SLOT_W'(p) >= best_pos) begin
                        n_order[p] = r_order[p + 1];
                    end
                end
                n_count = r_count - 1'b1;
            end else begin
                n_idle = new_idle;
            end
        end

        if (i_ctrl.do_assign) begin
            n_done      = 1'b1;
            n_o_dmask   = r_dmask;
            n_o_drop    = '0;
            n_o_created = 1'b0;
            if (found || can_create) begin
                for (int s = 0; s < N; s++) begin
                    if (r_in_use[s]) begin
                        n_age[s] = age_inc(r_age[s]);
                    end
                end
                if (found) begin
                    n_cur   = best_slot;
                    n_o_slot = best_slot;
                    n_o_age = age_inc(peak_age);
                end else begin
                    n_in_use[new_slot]                      = 1'b1;
                    n_busy[new_slot]                        = 1'b0;
                    n_age[new_slot]                         = '0;
                    n_order[r_count[abpm_pkg::SLOT_W-1:0]]  = new_slot;
                    n_count                                 = r_count + 1'b1;
                    n_cur                                   = new_slot;
                    n_o_slot                                = new_slot;
                    n_o_age                                 = '0;
                    n_o_created                             = 1'b1;
                end
                n_cur_v   = 1'b1;
                n_o_valid = 1'b1;
            end else begin
                n_age     = '0;
                n_cur_v   = 1'b0;
                n_o_slot  = '0;
                n_o_valid = 1'b0;
                n_o_age   = '0;
            end
        end

        if (i_ctrl.do_exec) begin
            n_done      = 1'b1;
            n_o_slot    = '0;
            n_o_valid   = 1'b0;
            n_o_age     = '0;
            n_o_created = 1'b0;
            n_o_dmask   = '0;
            n_o_drop    = '0;
            case (abpm_pkg::t_cmd'(r_cmd))
                abpm_pkg::CMD_POST: begin
                    n_cur_v = 1'b0;
                    if (r_cur_v && r_in_use[r_cur]) begin
                        n_busy[r_cur] = 1'b1;
                        n_age[r_cur]  = '0;
                        n_o_slot      = r_cur;
                        n_o_valid     = 1'b1;
                    end
                end
                abpm_pkg::CMD_RELEASE: begin
                    if (r_in_use[r_rel]) begin
                        n_busy[r_rel] = 1'b0;
                    end
                end
                abpm_pkg::CMD_RECONFIG: begin
                    if (r_size_ok) begin
                        n_o_dmask = r_in_use;
                        n_in_use  = '0;
                        n_busy    = '0;
                        n_age     = '0;
                        n_count   = '0;
                        n_cur_v   = 1'b0;
                    end
                end
                abpm_pkg::CMD_FLUSH: begin
                    n_o_dmask = r_purge ? r_in_use : (r_in_use & ~r_busy);
                    n_o_drop  = r_purge ? '0 : (r_in_use & r_busy);
                    if (r_in_use[r_cur]) begin
                        n_cur_v = 1'b0;
                    end
                    n_in_use = '0;
                    n_busy   = '0;
                    n_age    = '0;
                    n_count  = '0;
                end
                default: begin
                    n_o_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_busy   <= '0;
            r_age    <= '0;
            r_count  <= '0;
            r_cur    <= '0;
            r_cur_v  <= 1'b0;
            r_idle   <= '0;
            r_trim   <= abpm_pkg::TRIM_RESET;
            r_limit  <= abpm_pkg::LIMIT_RESET;
            r_done   <= 1'b0;
        end else begin
            r_in_use <= n_in_use;
            r_busy   <= n_busy;
            r_age    <= n_age;
            r_count  <= n_count;
            r_cur    <= n_cur;
            r_cur_v  <= n_cur_v;
            r_idle   <= n_idle;
            r_trim   <= n_trim;
            r_limit  <= n_limit;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_order     <= n_order;
        r_dmask     <= n_dmask;
        r_cmd       <= n_cmd;
        r_rel       <= n_rel;
        r_purge     <= n_purge;
        r_size_ok   <= n_size_ok;
        r_o_slot    <= n_o_slot;
        r_o_valid   <= n_o_valid;
        r_o_age     <= n_o_age;
        r_o_created <= n_o_created;
        r_o_dmask   <= n_o_dmask;
        r_o_drop    <= n_o_drop;
    end

    assign o_done         = r_done;
    assign o_result_slot  = r_o_slot;
    assign o_result_valid = r_o_valid;
    assign o_frame_age    = r_o_age;
    assign o_created      = r_o_created;
    assign o_destroy_mask = r_o_dmask;
    assign o_dropped_mask = r_o_drop;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == abpm_pkg::CNT_W'($countones(r_in_use)))
        else $error("pool count differs from the number of slots in use");

    a_busy_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy & ~r_in_use) == '0)
        else $error("busy flag set on a slot that is not in use");

    a_current_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_v |-> r_in_use[r_cur])
        else $error("current slot is not in use");

    a_result_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_o_valid) |-> r_in_use[r_o_slot])
        else $error("reported slot is not in use");

endmodule

// ===== rtl/aged_buffer_pool_manager.sv =====
`timescale 1ns / 1ps
// Aged buffer pool manager, top level: controller plus datapath.
// Depends on abpm_pkg, abpm_ctrl and abpm_dp.
// Sequencing: assign passes through the scan state, which trims one free slot per pass
// while the trim condition holds, and then the assign state, which updates the pool.
// Other commands go through the exec state. A new transfer is
// taken in the cycle the result is strobed. Synchronous active-low reset
// empties the pool and restores trim_limit 100 and buffer_limit 4.
module aged_buffer_pool_manager (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [abpm_pkg::CMD_W-1:0]          i_cmd,
    input  logic [abpm_pkg::SLOT_W-1:0]         i_slot,
    input  logic                                i_purge,
    input  logic [abpm_pkg::SIZE_W-1:0]         i_width,
    input  logic [abpm_pkg::SIZE_W-1:0]         i_height,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_addr,
    input  logic [abpm_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_done,
    output logic [abpm_pkg::SLOT_W-1:0]         o_result_slot,
    output logic                                o_result_valid,
    output logic [abpm_pkg::AGE_W-1:0]          o_frame_age,
    output logic                                o_created,
    output logic [abpm_pkg::NUM_SLOTS-1:0]      o_destroy_mask,
    output logic [abpm_pkg::NUM_SLOTS-1:0]      o_dropped_mask
);

    abpm_pkg::t_dp_ctrl   dp_ctrl;
    abpm_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    abpm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_status (dp_status),
        .busy     (busy),
        .o_ctrl   (dp_ctrl)
    );

    abpm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (dp_ctrl),
        .o_status       (dp_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_slot         (i_slot),
        .i_purge        (i_purge),
        .i_width        (i_width),
        .i_height       (i_height),
        .o_done         (o_done),
        .o_result_slot  (o_result_slot),
        .o_result_valid (o_result_valid),
        .o_frame_age    (o_frame_age),
        .o_created      (o_created),
        .o_destroy_mask (o_destroy_mask),
        .o_dropped_mask (o_dropped_mask)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the aged buffer pool manager.
// A scoreboard class tracks the slot pool and checks every result strobe.
// Depends on abpm_pkg and the aged_buffer_pool_manager top level.
module tb_top;
    import abpm_pkg::*;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PHASES    = 9;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int SATURATE_ASSIGNS = 40;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic                 valid;
        logic [AGE_W-1:0]     age;
        logic                 created;
        logic [NUM_SLOTS-1:0] destroyed;
        logic [NUM_SLOTS-1:0] dropped;
    } t_pool_result;

    class pool_tracker;
        logic [TRIM_W-1:0]  trim_limit;
        logic [LIMIT_W-1:0] buf_limit;
        logic               in_use[NUM_SLOTS];
        logic               held[NUM_SLOTS];
        logic [AGE_W-1:0]   age[NUM_SLOTS];
        logic [SLOT_W-1:0]  order[NUM_SLOTS];
        int                 pool_count;
        logic [SLOT_W-1:0]  cur_slot;
        logic               cur_valid;
        logic [IDLE_W-1:0]  idle_run;
        t_pool_result       pending_results[$];
        int errors, n_commands, n_checked, n_created, n_trimmed, n_failed, n_dropped;
        int n_saturated;

        function new();
            trim_limit = TRIM_RESET;
            buf_limit  = LIMIT_RESET;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                in_use[i] = 0;
                held[i]   = 0;
                age[i]    = '0;
                order[i]  = '0;
            end
            pool_count = 0;
            cur_slot   = '0;
            cur_valid  = 0;
            idle_run   = '0;
            errors = 0;
            n_commands = 0;
            n_checked = 0;
            n_created = 0;
            n_trimmed = 0;
            n_failed = 0;
            n_dropped = 0;
            n_saturated = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(t_cfg_addr addr, logic [CFG_W-1:0] data);
            if (addr == CFG_TRIM) begin
                trim_limit = data[TRIM_W-1:0];
            end else begin
                buf_limit = data[LIMIT_W-1:0];
            end
        endfunction

        function void drop_entry(int pos);
            logic [SLOT_W-1:0] s;
            s = order[pos];
            for (int p = pos; p + 1 < pool_count; p++) order[p] = order[p + 1];
            pool_count--;
            in_use[s] = 0;
            held[s]   = 0;
            age[s]    = '0;
            if (cur_valid && cur_slot == s) cur_valid = 0;
        endfunction

        function t_pool_result run_assign();
            t_pool_result r;
            int free_cnt, best_pos, eff_limit;
            logic found, have;
            logic [AGE_W-1:0] peak_age;
            logic [SLOT_W-1:0] s, pick;
            r = '0;
            have = 0;
            pick = '0;
            eff_limit = (buf_limit > NUM_SLOTS) ? NUM_SLOTS : int'(buf_limit);
            while (1) begin
                free_cnt = 0;
                found = 0;
                best_pos = 0;
                peak_age = '0;
                for (int p = 0; p < pool_count; p++) begin
                    s = order[p];
                    if (held[s]) continue;
                    free_cnt++;
                    if (!found || age[s] > peak_age) begin
                        found = 1;
                        best_pos = p;
                        peak_age = age[s];
                    end
                end
                if (free_cnt >= 2) begin
                    if (idle_run != IDLE_MAX) idle_run++;
                end else begin
                    idle_run = '0;
                end
                if (found && idle_run > trim_limit) begin
                    idle_run = '0;
                    r.destroyed[order[best_pos]] = 1'b1;
                    n_trimmed++;
                    drop_entry(best_pos);
                end else begin
                    if (found) begin
                        have = 1;
                        pick = order[best_pos];
                    end
                    break;
                end
            end
            if (!have && pool_count < eff_limit) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!have && !in_use[i]) begin
                        in_use[i] = 1;
                        held[i]   = 0;
                        age[i]    = '0;
                        order[pool_count] = SLOT_W'(i);
                        pool_count++;
                        pick = SLOT_W'(i);
                        have = 1;
                        r.created = 1'b1;
                    end
                end
            end
            if (!have) begin
                for (int p = 0; p < pool_count; p++) age[order[p]] = '0;
                cur_valid = 0;
                n_failed++;
                return r;
            end
            for (int p = 0; p < pool_count; p++) begin
                s = order[p];
                if (r.created && s == pick) continue;
                if (age[s] != AGE_MAX) age[s]++;
            end
            cur_slot  = pick;
            cur_valid = 1;
            r.slot  = pick;
            r.valid = 1'b1;
            r.age   = age[pick];
            if (r.created) n_created++;
            if (r.age == AGE_MAX) n_saturated++;
            return r;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                   logic purge, logic [SIZE_W-1:0] w,
                                   logic [SIZE_W-1:0] h);
            t_pool_result r;
            logic [SLOT_W-1:0] s;
            r = '0;
            n_commands++;
            case (cmd)
                CMD_ASSIGN: r = run_assign();
                CMD_POST: begin
                    if (cur_valid && in_use[cur_slot]) begin
                        held[cur_slot] = 1;
                        age[cur_slot]  = '0;
                        r.slot  = cur_slot;
                        r.valid = 1'b1;
                    end
                    cur_valid = 0;
                end
                CMD_RELEASE: begin
                    if (in_use[slot]) held[slot] = 0;
                end
                CMD_RECONFIG: begin
                    if (w != '0 && h != '0) begin
                        while (pool_count > 0) begin
                            r.destroyed[order[0]] = 1'b1;
                            drop_entry(0);
                        end
                        cur_valid = 0;
                    end
                end
                CMD_FLUSH: begin
                    while (pool_count > 0) begin
                        s = order[0];
                        if (purge || !held[s]) begin
                            r.destroyed[s] = 1'b1;
                        end else begin
                            r.dropped[s] = 1'b1;
                            n_dropped++;
                        end
                        drop_entry(0);
                    end
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [AGE_W-1:0] want,
                                    logic [AGE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_pool_result got);
            t_pool_result want;
            if (pending_results.size() == 0) begin
                $error("result strobe with nothing outstanding (slot %0d)", got.slot);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            compare_field("result_slot", AGE_W'(want.slot), AGE_W'(got.slot));
            compare_field("result_valid", AGE_W'(want.valid), AGE_W'(got.valid));
            compare_field("frame_age", want.age, got.age);
            compare_field("created", AGE_W'(want.created), AGE_W'(got.created));
            compare_field("destroy_mask", AGE_W'(want.destroyed), AGE_W'(got.destroyed));
            compare_field("dropped_mask", AGE_W'(want.dropped), AGE_W'(got.dropped));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [SLOT_W-1:0]    i_slot = '0;
    logic                 i_purge = 1'b0;
    logic [SIZE_W-1:0]    i_width = '0;
    logic [SIZE_W-1:0]    i_height = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_addr = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    logic [SLOT_W-1:0]    o_result_slot;
    logic                 o_result_valid;
    logic [AGE_W-1:0]     o_frame_age;
    logic                 o_created;
    logic [NUM_SLOTS-1:0] o_destroy_mask;
    logic [NUM_SLOTS-1:0] o_dropped_mask;

    pool_tracker pool;
    int  quiet_cycles = 0;
    int  n_reg_writes = 0;
    bit  allow_gaps = 1'b1;

    aged_buffer_pool_manager u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_slot         (i_slot),
        .i_purge        (i_purge),
        .i_width        (i_width),
        .i_height       (i_height),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_result_slot  (o_result_slot),
        .o_result_valid (o_result_valid),
        .o_frame_age    (o_frame_age),
        .o_created      (o_created),
        .o_destroy_mask (o_destroy_mask),
        .o_dropped_mask (o_dropped_mask)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                pool.note_command(i_cmd, i_slot, i_purge, i_width, i_height);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                pool.write_reg(t_cfg_addr'(i_cfg_addr), i_cfg_data);
                n_reg_writes++;
                moved = 1'b1;
            end
            if (o_done) begin
                pool.check_result('{o_result_slot, o_result_valid, o_frame_age, o_created,
                                    o_destroy_mask, o_dropped_mask});
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** aged_buffer_pool_manager: FAILED **");
        $finish;
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot, logic purge,
                             logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        start    <= 1'b1;
        i_cmd    <= cmd;
        i_slot   <= slot;
        i_purge  <= purge;
        i_width  <= w;
        i_height <= h;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start    <= 1'b0;
            i_cmd    <= CMD_W'($urandom());
            i_slot   <= SLOT_W'($urandom());
            i_purge  <= 1'($urandom());
            i_width  <= SIZE_W'($urandom());
            i_height <= SIZE_W'($urandom());
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pool();
        start <= 1'b0;
        do @(posedge i_clk); while (pool.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [TRIM_W-1:0] trim, logic [LIMIT_W-1:0] lim);
        t_cfg_addr        addrs[2];
        logic [CFG_W-1:0] vals[2];
        addrs[0] = CFG_TRIM;
        addrs[1] = CFG_LIMIT;
        vals[0]  = trim;
        vals[1]  = {7'($urandom()), lim};
        drain_pool();
        for (int r = 0; r < 2; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= addrs[r];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int roll;
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] w, h;
        roll = $urandom_range(0, 99);
        if (roll < 40)      cmd = CMD_ASSIGN;
        else if (roll < 65) cmd = CMD_POST;
        else if (roll < 85) cmd = CMD_RELEASE;
        else if (roll < 91) cmd = CMD_RECONFIG;
        else if (roll < 97) cmd = CMD_FLUSH;
        else                cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        w = ($urandom_range(0, 3) == 0) ? '0 : SIZE_W'($urandom());
        h = ($urandom_range(0, 3) == 0) ? '0 : SIZE_W'($urandom());
        send_item(cmd, SLOT_W'($urandom()), 1'($urandom()), w, h);
        if ($urandom_range(0, 99) == 0) drain_pool();
    endtask

    initial begin
        logic [TRIM_W-1:0]  trim;
        logic [LIMIT_W-1:0] lim;
        pool = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the pool with default settings, then exhaust it.
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_POST, '0, 1'b0, '0, '0);
        send_item(CMD_POST, '0, 1'b0, '0, '0);
        for (int i = 0; i < 3; i++) begin
            send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
            send_item(CMD_POST, '0, 1'b0, '0, '0);
        end
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_RELEASE, 2'd0, 1'b0, '0, '0);
        send_item(CMD_RELEASE, 2'd2, 1'b0, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_RECONFIG, '0, 1'b0, '0, '1);
        send_item(CMD_RECONFIG, '0, 1'b0, '1, '0);
        send_item(CMD_RECONFIG, '0, 1'b0, '1, '1);
        send_item(CMD_RELEASE, 2'd3, 1'b0, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_POST, '0, 1'b0, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_FLUSH, '0, 1'b0, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_POST, '0, 1'b0, '0, '0);
        send_item(CMD_FLUSH, '0, 1'b1, '0, '0);
        send_item(CMD_SPARE_LO, '1, 1'b1, '1, '1);
        send_item(CMD_SPARE_HI, '1, 1'b1, '1, '1);

        // Immediate trimming, then no allowed buffers, then a limit above the pool size.
        configure('0, 3'd4);
        for (int i = 0; i < 2; i++) begin
            send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
            send_item(CMD_POST, '0, 1'b0, '0, '0);
        end
        send_item(CMD_RELEASE, 2'd0, 1'b0, '0, '0);
        send_item(CMD_RELEASE, 2'd1, 1'b0, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        configure(10'd5, 3'd0);
        send_item(CMD_FLUSH, '0, 1'b1, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        configure(TRIM_RESET, 3'd7);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);

        // Age a busy and a free slot together, then release the busy one and assign.
        allow_gaps = 1'b0;
        configure(TRIM_RESET, 3'd2);
        send_item(CMD_FLUSH, '0, 1'b1, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_POST, '0, 1'b0, '0, '0);
        for (int i = 0; i < SATURATE_ASSIGNS; i++) send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_RELEASE, 2'd0, 1'b0, '0, '0);
        send_item(CMD_ASSIGN, '0, 1'b0, '0, '0);
        send_item(CMD_FLUSH, '0, 1'b0, '0, '0);
        allow_gaps = 1'b1;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin trim = '0;    lim = 3'd4; end
                1: begin trim = '1;    lim = 3'd4; end
                2: begin trim = 10'd1; lim = 3'd1; end
                3: begin trim = 10'd2; lim = 3'd0; end
                4: begin trim = TRIM_W'($urandom_range(0, 7)); lim = 3'd7; end
                default: begin
                    trim = $urandom_range(0, 1) ? TRIM_W'($urandom_range(0, 7))
                                                : TRIM_W'($urandom_range(0, 1023));
                    lim  = ($urandom_range(0, 9) < 8) ? LIMIT_W'($urandom_range(1, 4))
                                                      : LIMIT_W'($urandom_range(0, 7));
                end
            endcase
            configure(trim, lim);
            if (ph == RANDOM_PHASES - 1) allow_gaps = 1'b0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
        end

        drain_pool();
        $display("Covered %0d commands, %0d checked results and %0d register writes.",
                 pool.n_commands, pool.n_checked, n_reg_writes);
        $display("Pool events: %0d creations, %0d trims, %0d failed assigns,",
                 pool.n_created, pool.n_trimmed, pool.n_failed);
        $display("%0d dropped, %0d saturated.", pool.n_dropped, pool.n_saturated);
        if (pool.errors == 0) begin
            $display("** aged_buffer_pool_manager: PASSED **");
        end else begin
            $display("** aged_buffer_pool_manager: FAILED **");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/abpm_pkg.sv
rtl/abpm_ctrl.sv
rtl/abpm_dp.sv
rtl/aged_buffer_pool_manager.sv
test/tb_top.sv
